[rtl/bm3_pkg.sv]
// Package for the 3x3 binary morphology block: sizes, register indexes and codes,
// and the queue item passed from the front end to the window back end.
// Stand-alone; every other file of the block imports it.
package bm3_pkg;

    // Image geometry limits and derived counter widths.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    // The row counter runs one row past the image plus the flush column.
    localparam int ROW_W      = $clog2(MAX_HEIGHT + 2);

    // Register and pixel field widths.
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;

    // Queue between front end and back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MODE   = 2'd0;
    localparam t_cfg_idx CFG_WIDTH  = 2'd1;
    localparam t_cfg_idx CFG_HEIGHT = 2'd2;

    // Operating modes and item kinds.
    localparam logic MODE_ERODE  = 1'b0;
    localparam logic MODE_DILATE = 1'b1;
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_PAD    = 1'b1;

    // Channel thresholds.
    localparam logic [CH_W-1:0] CH_MAX  = 8'd255;
    localparam logic [CH_W-1:0] CH_MIN  = 8'd0;
    localparam logic [CH_W-1:0] CH_HALF = 8'd128;

    // One classified stream item.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;    // pixel to store (black for pads)
        logic [COL_W-1:0] col;      // line memory column
        logic             store;    // item lies inside the image rows
        logic             emit;     // item completes an output pixel
        logic             mode;     // morphology mode for this pixel
        logic             top_ok;   // row above the center is in the image
        logic             bot_ok;   // row below the center is in the image
        logic             left_ok;  // column left of the center is in the image
        logic             right_ok; // column right of the center is in the image
        logic             last;     // center is the last pixel of the frame
    } t_item;

endpackage

[rtl/bm3_front.sv]
// Front end of the 3x3 morphology block: configuration registers, stream position
// counters and per-item classification into a queue item.
// Depends on bm3_pkg.
module bm3_front
    import bm3_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    input  logic                  i_kind,
    input  logic [CH_W-1:0]       i_red,
    input  logic [CH_W-1:0]       i_green,
    input  logic [CH_W-1:0]       i_blue,
    output t_item                 o_item
);

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd258;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd288;

    logic                r_mode;
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;

    logic [WIDTH_W-1:0]  n_width;
    logic [HEIGHT_W-1:0] n_height;
    logic [COL_W-1:0]    n_col;
    logic [ROW_W-1:0]    n_row;
    logic [WIDTH_W-1:0]  col_inc;
    logic [ROW_W-1:0]    row_lim;
    logic                col0;
    logic                geom_write;

    // Clamp written geometry to the supported range.
    always_comb begin
        n_width = i_cfg_data[WIDTH_W-1:0];
        if (n_width < WIDTH_W'(2)) begin
            n_width = WIDTH_W'(2);
        end else if (n_width > WIDTH_W'(MAX_WIDTH)) begin
            n_width = WIDTH_W'(MAX_WIDTH);
        end
        n_height = i_cfg_data[HEIGHT_W-1:0];
        if (n_height < HEIGHT_W'(2)) begin
            n_height = HEIGHT_W'(2);
        end else if (n_height > HEIGHT_W'(MAX_HEIGHT)) begin
            n_height = HEIGHT_W'(MAX_HEIGHT);
        end
    end

    assign geom_write = i_cfg_we && (i_cfg_index == CFG_WIDTH || i_cfg_index == CFG_HEIGHT);
    assign col0       = (r_col == '0);
    assign col_inc    = WIDTH_W'(r_col) + WIDTH_W'(1);
    assign row_lim    = ROW_W'(r_height);

    // Classify the item at the current position. The output center lags by one
    // row and one pixel; at column zero it wraps to the end of the row two back.
    always_comb begin
        o_item.pixel = (i_kind == KIND_PIXEL) ? {i_red, i_green, i_blue} : '0;
        o_item.col   = r_col;
        o_item.store = (r_row < row_lim);
        o_item.emit  = (r_row >= ROW_W'(2)) || (r_row == ROW_W'(1) && !col0);
        o_item.mode  = r_mode;
        if (col0) begin
            o_item.top_ok   = (r_row >= ROW_W'(3));
            o_item.bot_ok   = (r_row <= row_lim);
            o_item.left_ok  = 1'b1;
            o_item.right_ok = 1'b0;
            o_item.last     = (r_row == row_lim + ROW_W'(1));
        end else begin
            o_item.top_ok   = (r_row >= ROW_W'(2));
            o_item.bot_ok   = (r_row < row_lim);
            o_item.left_ok  = (r_col >= COL_W'(2));
            o_item.right_ok = 1'b1;
            o_item.last     = 1'b0;
        end
    end

    // Next stream position after an accepted item.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (geom_write) begin
            n_col = '0;
            n_row = '0;
        end else if (i_accept) begin
            if (o_item.last) begin
                n_col = '0;
                n_row = '0;
            end else if (col_inc >= r_width) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = col_inc[COL_W-1:0];
            end
        end
    end

    // Configuration registers and position counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_ERODE;
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MODE:   r_mode   <= i_cfg_data[0];
                    CFG_WIDTH:  r_width  <= n_width;
                    CFG_HEIGHT: r_height <= n_height;
                    default:    ;
                endcase
            end
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

[rtl/bm3_fifo.sv]
// Short item queue that decouples the front end from the window back end.
// Depends on bm3_pkg for the item type and depth.
module bm3_fifo
    import bm3_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/bm3_back.sv]
// Back end of the 3x3 morphology block: two line memories, the 3x3 window,
// the neighbor test and the output register.
// Depends on bm3_pkg for the item type and constants.
module bm3_back
    import bm3_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  t_item           i_q_item,
    output logic            o_pop,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output logic [CH_W-1:0] o_out_red,
    output logic [CH_W-1:0] o_out_green,
    output logic [CH_W-1:0] o_out_blue,
    output logic            o_frame_end
);

    // Line memories: upper holds the row two back, middle the row one back.
    logic [PIX_W-1:0] mem_upper  [MAX_WIDTH];
    logic [PIX_W-1:0] mem_middle [MAX_WIDTH];

    logic [PIX_W-1:0] r_rd_upper;
    logic [PIX_W-1:0] r_rd_middle;
    logic             r_s1_valid;
    t_item            r_s1;
    logic             r_s2_valid;
    t_item            r_s2;
    logic [PIX_W-1:0] r_win [3][3];
    logic [PIX_W-1:0] r_out_pix;
    logic             r_out_last;
    logic             r_out_valid;

    logic             adv;
    logic             hit;
    logic             bright;
    logic             use_nb;
    logic [CH_W-1:0]  nb_red;
    logic [PIX_W-1:0] center;
    logic [PIX_W-1:0] n_out_pix;

    // The whole pipeline moves when the output register is free or being taken.
    assign adv   = !r_out_valid || i_out_ready;
    assign o_pop = adv && i_q_valid;

    // Line memory read on pop, write-back when the item enters the window.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_upper  <= mem_upper[i_q_item.col];
            r_rd_middle <= mem_middle[i_q_item.col];
        end
        if (adv && r_s1_valid && r_s1.store) begin
            mem_upper[r_s1.col]  <= r_rd_middle;
            mem_middle[r_s1.col] <= r_s1.pixel;
        end
    end

    // Stage payloads and window shift; the new right column is the memory pair
    // plus the incoming pixel.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1 <= i_q_item;
        end
        if (adv && r_s1_valid) begin
            r_s2 <= r_s1;
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= r_rd_upper;
            r_win[1][2] <= r_rd_middle;
            r_win[2][2] <= r_s1.pixel;
        end
        if (adv && r_s2_valid && r_s2.emit) begin
            r_out_pix  <= n_out_pix;
            r_out_last <= r_s2.last;
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= i_q_valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid && r_s2.emit;
        end
    end

    // Neighbor test over the eight in-image window positions.
    always_comb begin
        hit = 1'b0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                use_nb = !(r == 1 && c == 1);
                if (r == 0) use_nb = use_nb && r_s2.top_ok;
                if (r == 2) use_nb = use_nb && r_s2.bot_ok;
                if (c == 0) use_nb = use_nb && r_s2.left_ok;
                if (c == 2) use_nb = use_nb && r_s2.right_ok;
                nb_red = r_win[r][c][PIX_W-1 -: CH_W];
                if (use_nb) begin
                    if (r_s2.mode == MODE_ERODE) begin
                        hit = hit || (nb_red == CH_MAX);
                    end else begin
                        hit = hit || (nb_red == CH_MIN);
                    end
                end
            end
        end
    end

    // Result for the center pixel.
    always_comb begin
        center = r_win[1][1];
        bright = (center[PIX_W-1 -: CH_W] >= CH_HALF)
              && (center[2*CH_W-1 -: CH_W] >= CH_HALF)
              && (center[CH_W-1:0] >= CH_HALF);
        if (r_s2.mode == MODE_ERODE) begin
            n_out_pix = (bright || hit) ? '1 : center;
        end else begin
            n_out_pix = hit ? '0 : center;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_red   = r_out_pix[PIX_W-1 -: CH_W];
    assign o_out_green = r_out_pix[2*CH_W-1 -: CH_W];
    assign o_out_blue  = r_out_pix[CH_W-1:0];
    assign o_frame_end = r_out_last;

endmodule

[rtl/binary_morphology_3x3.sv]
// Top level of the 3x3 binary morphology block: front end, item queue and back end.
// Depends on bm3_pkg, bm3_front, bm3_fifo and bm3_back.
//
// The block takes one RGB item (pixel or pad) per clock in raster order while the
// queue has room, and gives one result per clock once the window is full while the
// output is ready; a frame of W by H pixels needs W*H items plus W+1 pad items to
// flush. Results lag the input stream by one row plus one pixel, and each result
// passes the queue entry, line memory read, window register and output register
// after the transfer of the item that completes it. Two line memories of 1024 by
// 24 bits, each read once and written once per clock, hold the two previous rows;
// a four-entry queue lets the input side keep flowing while the output is stalled,
// until the queue is full. Writing the width or height register restarts the frame
// at the first pixel; a mode write takes effect on the next item.
module binary_morphology_3x3
    import bm3_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_kind,
    input  logic [CH_W-1:0]       i_red,
    input  logic [CH_W-1:0]       i_green,
    input  logic [CH_W-1:0]       i_blue,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CH_W-1:0]       o_out_red,
    output logic [CH_W-1:0]       o_out_green,
    output logic [CH_W-1:0]       o_out_blue,
    output logic                  o_frame_end
);

    t_item front_item;
    t_item q_item;
    logic  accept;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;

    // An offered input transfer takes place whenever the queue has room.
    assign o_in_ready = !q_full;
    assign accept     = i_in_valid && o_in_ready;

    bm3_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_kind      (i_kind),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .o_item      (front_item)
    );

    bm3_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    bm3_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (q_pop),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_frame_end (o_frame_end)
    );

endmodule

[rtl/bm3_checker.sv]
// Port-level checks for the 3x3 morphology block, bound to its top level.
// Depends on bm3_pkg for port widths.
module bm3_checker
    import bm3_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  i_kind,
    input logic [CH_W-1:0]       i_red,
    input logic [CH_W-1:0]       i_green,
    input logic [CH_W-1:0]       i_blue,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [CH_W-1:0]       o_out_red,
    input logic [CH_W-1:0]       o_out_green,
    input logic [CH_W-1:0]       o_out_blue,
    input logic                  o_frame_end
);

    // A waiting input transfer stays offered with the same payload.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid
            && $stable({i_kind, i_red, i_green, i_blue}))
        else $error("waiting input changed or dropped");

    // A stalled result stays offered with the same payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid
            && $stable({o_out_red, o_out_green, o_out_blue, o_frame_end}))
        else $error("stalled result changed or dropped");

    // Reset leaves no result pending.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

    // Reset empties the queue, so the input side is ready.
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready right after reset");

    // With the output side ready, the queue drains as fast as it fills.
    a_no_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready && o_in_ready |=> o_in_ready)
        else $error("queue filled while the output was ready");

endmodule

bind binary_morphology_3x3 bm3_checker u_bm3_checker (.*);

[tb/bm3_stream_checker.sv]
// Checker for the 3x3 binary morphology block: follows the configuration writes and both
// transfer channels, predicts every output pixel and compares it field by field.
// Depends on bm3_pkg for widths, register indexes, modes, item kinds and thresholds.
module bm3_stream_checker
    import bm3_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_kind,
    input  logic [CH_W-1:0]       i_red,
    input  logic [CH_W-1:0]       i_green,
    input  logic [CH_W-1:0]       i_blue,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [CH_W-1:0]       i_out_red,
    input  logic [CH_W-1:0]       i_out_green,
    input  logic [CH_W-1:0]       i_out_blue,
    input  logic                  i_frame_end,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_WIDTH  = 258;
    localparam int RESET_HEIGHT = 288;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            frame_end;
    } t_result;

    // Four rows of pixels indexed by row modulo four: enough to hold the rows above,
    // at and below the pixel being finished while the next row is written.
    t_pixel  pixel_rows [4][MAX_WIDTH];
    int      col_pos;
    int      row_pos;
    int      img_w;
    int      img_h;
    logic    cur_mode;
    t_result expected_pixels [$];
    int      fail_count;

    // Takes one stream item, stores it if it lies in the image, and returns 1 with the
    // finished pixel one row plus one pixel behind when the item completes one.
    function automatic bit morph_next_pixel(input logic kind, input t_pixel px,
                                            output t_result res);
        int     r;
        int     c;
        int     orow;
        int     ocol;
        int     nr;
        int     nc;
        int     dr;
        int     dc;
        t_pixel center;
        t_pixel value;
        bit     emits;
        bit     hit;
        bit     bright;
        bit     last;

        r = row_pos;
        c = col_pos;
        res = '0;
        hit = 1'b0;
        last = 1'b0;

        // Pads inside the image are kept as black; anything past the last row is dropped.
        if (r < img_h) begin
            pixel_rows[r % 4][c] = (kind == KIND_PAD) ? t_pixel'('0) : px;
        end

        emits = !(r == 0 || (r == 1 && c == 0));
        if (emits) begin
            if (c >= 1) begin
                orow = r - 1;
                ocol = c - 1;
            end else begin
                orow = r - 2;
                ocol = img_w - 1;
            end
            center = pixel_rows[orow % 4][ocol];

            // Look for a trigger red value among the eight neighbors inside the image.
            for (dr = -1; dr <= 1; dr++) begin
                for (dc = -1; dc <= 1; dc++) begin
                    nr = orow + dr;
                    nc = ocol + dc;
                    if ((dr != 0 || dc != 0) && nr >= 0 && nr < img_h
                            && nc >= 0 && nc < img_w) begin
                        if (cur_mode == MODE_ERODE) begin
                            if (pixel_rows[nr % 4][nc].red == CH_MAX) hit = 1'b1;
                        end else begin
                            if (pixel_rows[nr % 4][nc].red == CH_MIN) hit = 1'b1;
                        end
                    end
                end
            end

            if (cur_mode == MODE_ERODE) begin
                bright = center.red >= CH_HALF && center.green >= CH_HALF
                         && center.blue >= CH_HALF;
                value = (bright || hit) ? t_pixel'('1) : center;
            end else begin
                value = hit ? t_pixel'('0) : center;
            end

            last = (orow == img_h - 1) && (ocol == img_w - 1);
            res.red = value.red;
            res.green = value.green;
            res.blue = value.blue;
            res.frame_end = last;
        end

        // Advance the stream position; the frame end sends it back to the first pixel.
        if (last) begin
            col_pos = 0;
            row_pos = 0;
        end else begin
            col_pos = c + 1;
            if (col_pos >= img_w) begin
                col_pos = 0;
                row_pos = r + 1;
            end
        end
        return emits;
    endfunction

    function automatic void check_field(input string field, input logic [CH_W-1:0] want,
                                        input logic [CH_W-1:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    // Configuration, input transfers and output transfers, all seen at the clock edge.
    always @(posedge i_clk) begin : follow_stream
        t_result res;
        t_result want;

        if (!i_rst_n) begin
            col_pos = 0;
            row_pos = 0;
            cur_mode = MODE_ERODE;
            img_w = RESET_WIDTH;
            img_h = RESET_HEIGHT;
            expected_pixels.delete();
            fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MODE: begin
                        cur_mode = i_cfg_data[0];
                    end
                    CFG_WIDTH: begin
                        img_w = i_cfg_data[WIDTH_W-1:0];
                        if (img_w < 2) img_w = 2;
                        if (img_w > MAX_WIDTH) img_w = MAX_WIDTH;
                        col_pos = 0;
                        row_pos = 0;
                    end
                    CFG_HEIGHT: begin
                        img_h = i_cfg_data[HEIGHT_W-1:0];
                        if (img_h < 2) img_h = 2;
                        if (img_h > MAX_HEIGHT) img_h = MAX_HEIGHT;
                        col_pos = 0;
                        row_pos = 0;
                    end
                    default: begin
                    end
                endcase
            end

            if (i_in_valid && i_in_ready) begin
                if (morph_next_pixel(i_kind, {i_red, i_green, i_blue}, res)) begin
                    expected_pixels = {expected_pixels, res};
                end
            end

            if (i_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected pixel, expected none, actual %0d %0d %0d end %0b",
                             $time, i_out_red, i_out_green, i_out_blue, i_frame_end);
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("red", want.red, i_out_red);
                    check_field("green", want.green, i_out_green);
                    check_field("blue", want.blue, i_out_blue);
                    check_field("frame_end", CH_W'(want.frame_end), CH_W'(i_frame_end));
                end
            end
        end
        o_pending <= expected_pixels.size();
        o_fail_count <= fail_count;
    end

endmodule

[tb/tb_binary_morphology_3x3.sv]
// Testbench top for the 3x3 binary morphology block: clock, reset, configuration writes,
// pixel and pad stimulus and the result sink; the verdict comes from bm3_stream_checker.
// Depends on bm3_pkg, binary_morphology_3x3 and bm3_stream_checker.
module tb_binary_morphology_3x3
    import bm3_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_ITEMS     = 1420;
    localparam int CALM_ITEMS      = 200;
    localparam int WIDE_EXTRA      = 24;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 12;
    localparam int CYCLE_LIMIT     = 400000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_MODE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_kind = KIND_PIXEL;
    logic [CH_W-1:0]       i_red = '0;
    logic [CH_W-1:0]       i_green = '0;
    logic [CH_W-1:0]       i_blue = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [CH_W-1:0]       o_out_red;
    logic [CH_W-1:0]       o_out_green;
    logic [CH_W-1:0]       o_out_blue;
    logic                  o_frame_end;

    int fail_total;
    int pending_results;
    int items_sent = 0;
    int cycle_count = 0;
    bit idling = 1'b0;
    bit calm = 1'b0;
    bit hold_request = 1'b0;

    binary_morphology_3x3 u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_frame_end (o_frame_end)
    );

    bm3_stream_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_red    (o_out_red),
        .i_out_green  (o_out_green),
        .i_out_blue   (o_out_blue),
        .i_frame_end  (o_frame_end),
        .o_fail_count (fail_total),
        .o_pending    (pending_results)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result sink: random stalls, plus one long hold-off on request so the block fills up.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left = HOLD_OFF_CYCLES;
            end else if (stall_left == 0 && idling && !calm && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(1, 16);
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic logic [CH_W-1:0] pick_channel(input int unsigned bias);
        if ($urandom_range(0, 99) >= bias) return CH_W'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0: return CH_MIN;
            1: return CH_MAX;
            2: return CH_HALF;
            default: return CH_HALF - 1'b1;
        endcase
    endfunction

    // Mode word with random upper bits; only bit 0 carries the mode.
    function automatic logic [CFG_DATA_W-1:0] mode_word(input logic mode);
        logic [CFG_DATA_W-1:0] word;
        word = CFG_DATA_W'($urandom);
        word[0] = mode;
        return word;
    endfunction

    function automatic int clamp_dim(input int value, input int limit);
        return (value < 2) ? 2 : (value > limit) ? limit : value;
    endfunction

    // Write enable is left high so back-to-back writes never drop it; callers lower it.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic setup_frame(input logic mode, input logic [CFG_DATA_W-1:0] width_data,
                               input logic [CFG_DATA_W-1:0] height_data);
        write_reg(CFG_MODE, mode_word(mode));
        write_reg(CFG_WIDTH, width_data);
        write_reg(CFG_HEIGHT, height_data);
        i_cfg_we <= 1'b0;
        idling = !calm && $urandom_range(0, 3) != 0;
    endtask

    // One input transfer, sometimes after a burst of idle cycles. Valid stays high
    // afterwards so that back-to-back items never drop it within a time step.
    task automatic send_item(input logic kind, input logic [CH_W-1:0] red,
                             input logic [CH_W-1:0] green, input logic [CH_W-1:0] blue);
        if (idling && $urandom_range(0, 9) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_red <= red;
        i_green <= green;
        i_blue <= blue;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_pixel(input int unsigned bias, input int unsigned pad_pct);
        send_item(($urandom_range(0, 99) < pad_pct) ? KIND_PAD : KIND_PIXEL,
                  pick_channel(bias), pick_channel(bias), pick_channel(bias));
    endtask

    // Stop offering items and wait until every predicted pixel has come out, then give
    // items that finish no pixel time to leave the pipeline.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int                    n;
        int                    f;
        int                    nframes;
        int                    cut;
        int                    bias;
        int                    w;
        int                    h;
        int                    sel;
        bit                    abandoned;
        logic [CFG_DATA_W-1:0] wdata;
        logic [CFG_DATA_W-1:0] hdata;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Smallest frame through out-of-range geometry writes; erode with threshold values.
        setup_frame(MODE_ERODE, CFG_DATA_W'(1), CFG_DATA_W'(0));
        send_item(KIND_PIXEL, 8'd127, 8'd200, 8'd200);
        send_item(KIND_PIXEL, CH_HALF, CH_HALF, CH_HALF);
        send_item(KIND_PIXEL, CH_MAX, CH_MIN, CH_MIN);
        send_item(KIND_PIXEL, CH_MIN, CH_MIN, CH_MIN);
        // Flush: a real pixel past the image must be ignored like a pad.
        send_item(KIND_PIXEL, CH_MAX, CH_MAX, CH_MAX);
        send_item(KIND_PAD, CH_MAX, CH_MAX, CH_MAX);
        send_item(KIND_PAD, CH_MIN, CH_MIN, CH_MIN);
        drain_results();

        // Dilate, with a pad inside the image that has to be stored as black.
        setup_frame(MODE_DILATE, CFG_DATA_W'(2), CFG_DATA_W'(2));
        send_item(KIND_PIXEL, CH_MIN, CH_MAX, CH_MAX);
        send_item(KIND_PIXEL, CH_MAX, CH_MAX, CH_MAX);
        send_item(KIND_PAD, 8'd17, 8'd34, 8'd51);
        send_item(KIND_PIXEL, 8'd1, 8'd2, 8'd3);
        send_item(KIND_PAD, 8'd85, 8'd170, CH_MAX);
        send_item(KIND_PIXEL, CH_MIN, CH_MIN, CH_MIN);
        send_item(KIND_PAD, CH_MIN, CH_MIN, CH_MIN);
        drain_results();

        // Erode with no full-red neighbor, so only the brightness test decides.
        setup_frame(MODE_ERODE, CFG_DATA_W'(2), CFG_DATA_W'(2));
        send_item(KIND_PIXEL, 8'd127, 8'd127, 8'd127);
        send_item(KIND_PIXEL, CH_HALF, 8'd127, CH_MAX);
        send_item(KIND_PIXEL, 8'd254, CH_HALF, CH_HALF);
        send_item(KIND_PIXEL, CH_HALF, CH_MAX, 8'd127);
        repeat (3) send_item(KIND_PAD, CH_MAX, CH_MAX, CH_MAX);
        drain_results();

        // Widest rows and tallest frame: one full row plus a little, with a long output
        // hold-off once pixels are coming out so the input side has to stall.
        setup_frame(1'($urandom_range(0, 1)), CFG_DATA_W'(2047), CFG_DATA_W'(4096));
        for (n = 0; n < MAX_WIDTH + 1 + WIDE_EXTRA; n++) begin
            if (n == MAX_WIDTH + 4) hold_request = 1'b1;
            send_pixel(20, 8);
        end
        drain_results();

        // Random frames, mostly small and complete, a few cut short or left unfinished.
        while (items_sent < TOTAL_ITEMS) begin
            if (items_sent > TOTAL_ITEMS - CALM_ITEMS) calm = 1'b1;

            sel = $urandom_range(0, 19);
            if (sel == 0) wdata = CFG_DATA_W'($urandom_range(0, 1));
            else if (sel < 4) wdata = CFG_DATA_W'($urandom_range(7, 40));
            else wdata = CFG_DATA_W'($urandom_range(2, 6));
            if ($urandom_range(0, 7) == 0) begin
                wdata[CFG_DATA_W-1:WIDTH_W] = (CFG_DATA_W - WIDTH_W)'($urandom);
            end

            sel = $urandom_range(0, 19);
            if (sel == 0) hdata = CFG_DATA_W'(8191);
            else if (sel == 1) hdata = CFG_DATA_W'($urandom_range(0, 1));
            else if (sel < 5) hdata = CFG_DATA_W'(2);
            else hdata = CFG_DATA_W'($urandom_range(2, 5));

            w = clamp_dim(wdata[WIDTH_W-1:0], MAX_WIDTH);
            h = clamp_dim(hdata, MAX_HEIGHT);
            setup_frame(1'($urandom_range(0, 1)), wdata, hdata);
            bias = $urandom_range(0, 40);

            if (h == MAX_HEIGHT) begin
                // This frame never reaches its end here; feed a few rows and stop mid-frame.
                repeat (w * $urandom_range(2, 4) + $urandom_range(0, w)) send_pixel(bias, 8);
            end else begin
                nframes = (w > 6) ? 1 : $urandom_range(1, 4);
                abandoned = 1'b0;
                for (f = 0; f < nframes && !abandoned; f++) begin
                    bias = $urandom_range(0, 40);
                    cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, w * h + w) : -1;
                    for (n = 0; n < w * h + w + 1 && !abandoned; n++) begin
                        if (n == cut) begin
                            // Pause mid-frame; either switch mode and carry on, or give up
                            // and let the next geometry write restart the frame.
                            drain_results();
                            if ($urandom_range(0, 1) == 0) begin
                                write_reg(CFG_MODE, mode_word(1'($urandom_range(0, 1))));
                                i_cfg_we <= 1'b0;
                            end else begin
                                abandoned = 1'b1;
                            end
                        end
                        if (!abandoned) send_pixel(bias, (n < w * h) ? 8 : 75);
                    end
                end
            end
            drain_results();
        end

        if (fail_total == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/bm3_pkg.sv
rtl/bm3_front.sv
rtl/bm3_fifo.sv
rtl/bm3_back.sv
rtl/binary_morphology_3x3.sv
rtl/bm3_checker.sv
tb/bm3_stream_checker.sv
tb/tb_binary_morphology_3x3.sv
